FILE: sv/bud_pkg.sv
`timescale 1ns / 1ps
package bud_pkg;

    localparam int POOL_LOG2 = 6;
    localparam int NODE_AW   = POOL_LOG2 + 1;
    localparam int NODES     = 1 << NODE_AW;

    typedef enum logic [1:0] {
        NODE_UNUSED = 2'd0,
        NODE_FREE   = 2'd1,
        NODE_USED   = 2'd2,
        NODE_SPLIT  = 2'd3
    } node_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FIT  = 2'd1,
        STAT_BAD_OFF = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_EV,
        ST_A_SPL,
        ST_A_SPR,
        ST_A_USE,
        ST_F_RD,
        ST_F_EV,
        ST_F_WR,
        ST_M_RD,
        ST_M_EV,
        ST_M_W1,
        ST_M_W2,
        ST_M_W3
    } st_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [NODE_AW-1:0] addr;
        node_t              wdata;
    } mem_req_t;

endpackage

FILE: sv/bud_node_mem.sv
`timescale 1ns / 1ps
module bud_node_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  bud_pkg::mem_req_t req,
    output bud_pkg::node_t    rd_state
);

    bud_pkg::node_t                   mem [bud_pkg::NODES];
    logic [bud_pkg::NODES-1:0]        valid_reg;
    bud_pkg::node_t                   data_reg;
    logic                             vld_reg;
    logic                             root_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            data_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_reg   <= 1'b0;
            root_reg  <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                vld_reg  <= valid_reg[req.addr];
                root_reg <= (req.addr == bud_pkg::NODE_AW'(1));
            end
        end
    end

    assign rd_state = vld_reg  ? data_reg :
                      root_reg ? bud_pkg::NODE_FREE : bud_pkg::NODE_UNUSED;

endmodule

FILE: sv/bud_ctrl.sv
`timescale 1ns / 1ps
module bud_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        pool_log2,
    input  logic              start,
    input  logic              operation,
    input  logic [6:0]        request_size,
    input  logic [5:0]        free_offset,
    input  bud_pkg::node_t    rd_state,
    output bud_pkg::mem_req_t req,
    output logic              busy,
    output logic              done,
    output logic [5:0]        block_offset,
    output logic [2:0]        block_size_log2,
    output logic [1:0]        status
);

    localparam int AW = bud_pkg::NODE_AW;

    bud_pkg::st_t     state_reg, state_next;
    logic [AW-1:0]    node_reg, node_next;
    logic [2:0]       dep_reg, dep_next;
    logic [2:0]       dmax_reg, dmax_next;
    logic [5:0]       off_reg, off_next;
    logic [5:0]       res_off_reg, res_off_next;
    logic [2:0]       res_sz_reg, res_sz_next;
    bud_pkg::status_t status_reg, status_next;
    logic             done_reg, done_next;

    logic [2:0]       k;
    logic [2:0]       tz;
    logic [AW-1:0]    up;
    logic [AW-1:0]    found_off;
    logic [AW-1:0]    low_mask;
    logic [2:0]       bit_sh;
    logic [AW-1:0]    node_x2;

    always_comb
    begin
        k = 3'd7;
        for (int i = bud_pkg::POOL_LOG2; i >= 0; i--)
        begin
            if ((8'd1 << i) >= {1'b0, request_size})
            begin
                k = 3'(i);
            end
        end
    end

    always_comb
    begin
        tz = 3'd0;
        for (int i = 0; i < AW; i++)
        begin
            if (&node_reg[i -: 1] && (tz == 3'(i)))
            begin
                tz = 3'(i + 1);
            end
        end
    end

    assign up        = node_reg >> tz;
    assign found_off = (node_reg ^ (AW'(1) << dep_reg)) << (pool_log2 - dep_reg);
    assign low_mask  = (AW'(1) << (pool_log2 - dep_reg)) - AW'(1);
    assign bit_sh    = pool_log2 - dep_reg - 3'd1;
    assign node_x2   = node_reg << 1;

    always_comb
    begin
        state_next   = state_reg;
        node_next    = node_reg;
        dep_next     = dep_reg;
        dmax_next    = dmax_reg;
        off_next     = off_reg;
        res_off_next = res_off_reg;
        res_sz_next  = res_sz_reg;
        status_next  = status_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            bud_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    node_next    = AW'(1);
                    dep_next     = 3'd0;
                    off_next     = free_offset;
                    res_off_next = 6'd0;
                    res_sz_next  = 3'd0;
                    dmax_next    = pool_log2 - k;
                    if (operation == bud_pkg::OP_ALLOC)
                    begin
                        res_sz_next = k;
                        if (k > pool_log2)
                        begin
                            res_sz_next = 3'd0;
                            status_next = bud_pkg::STAT_NO_FIT;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = bud_pkg::ST_A_RD;
                        end
                    end
                    else if ({1'b0, free_offset} >= (AW'(1) << pool_log2))
                    begin
                        status_next = bud_pkg::STAT_BAD_OFF;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = bud_pkg::ST_F_RD;
                    end
                end
            end
            bud_pkg::ST_A_RD:
            begin
                state_next = bud_pkg::ST_A_EV;
            end
            bud_pkg::ST_A_EV:
            begin
                if (rd_state == bud_pkg::NODE_FREE)
                begin
                    res_off_next = found_off[5:0];
                    state_next   = (dep_reg == dmax_reg) ? bud_pkg::ST_A_USE
                                                         : bud_pkg::ST_A_SPL;
                end
                else if (rd_state == bud_pkg::NODE_SPLIT && dep_reg < dmax_reg)
                begin
                    node_next  = node_x2;
                    dep_next   = dep_reg + 3'd1;
                    state_next = bud_pkg::ST_A_RD;
                end
                else if (up[AW-1:1] == '0)
                begin
                    res_sz_next = 3'd0;
                    status_next = bud_pkg::STAT_NO_FIT;
                    done_next   = 1'b1;
                    state_next  = bud_pkg::ST_IDLE;
                end
                else
                begin
                    node_next  = up + AW'(1);
                    dep_next   = dep_reg - tz;
                    state_next = bud_pkg::ST_A_RD;
                end
            end
            bud_pkg::ST_A_SPL:
            begin
                state_next = bud_pkg::ST_A_SPR;
            end
            bud_pkg::ST_A_SPR:
            begin
                node_next  = node_x2;
                dep_next   = dep_reg + 3'd1;
                state_next = (dep_reg + 3'd1 == dmax_reg) ? bud_pkg::ST_A_USE
                                                         : bud_pkg::ST_A_SPL;
            end
            bud_pkg::ST_A_USE:
            begin
                status_next = bud_pkg::STAT_OK;
                done_next   = 1'b1;
                state_next  = bud_pkg::ST_IDLE;
            end
            bud_pkg::ST_F_RD:
            begin
                state_next = bud_pkg::ST_F_EV;
            end
            bud_pkg::ST_F_EV:
            begin
                if (rd_state == bud_pkg::NODE_USED)
                begin
                    if (({1'b0, off_reg} & low_mask) == '0)
                    begin
                        res_off_next = off_reg;
                        res_sz_next  = pool_log2 - dep_reg;
                        state_next   = bud_pkg::ST_F_WR;
                    end
                    else
                    begin
                        status_next = bud_pkg::STAT_BAD_OFF;
                        done_next   = 1'b1;
                        state_next  = bud_pkg::ST_IDLE;
                    end
                end
                else if (rd_state == bud_pkg::NODE_SPLIT && dep_reg < pool_log2)
                begin
                    node_next  = node_x2 | AW'(off_reg[bit_sh]);
                    dep_next   = dep_reg + 3'd1;
                    state_next = bud_pkg::ST_F_RD;
                end
                else
                begin
                    status_next = bud_pkg::STAT_BAD_OFF;
                    done_next   = 1'b1;
                    state_next  = bud_pkg::ST_IDLE;
                end
            end
            bud_pkg::ST_F_WR:
            begin
                if (node_reg == AW'(1))
                begin
                    status_next = bud_pkg::STAT_OK;
                    done_next   = 1'b1;
                    state_next  = bud_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bud_pkg::ST_M_RD;
                end
            end
            bud_pkg::ST_M_RD:
            begin
                state_next = bud_pkg::ST_M_EV;
            end
            bud_pkg::ST_M_EV:
            begin
                if (rd_state == bud_pkg::NODE_FREE)
                begin
                    state_next = bud_pkg::ST_M_W1;
                end
                else
                begin
                    status_next = bud_pkg::STAT_OK;
                    done_next   = 1'b1;
                    state_next  = bud_pkg::ST_IDLE;
                end
            end
            bud_pkg::ST_M_W1:
            begin
                state_next = bud_pkg::ST_M_W2;
            end
            bud_pkg::ST_M_W2:
            begin
                state_next = bud_pkg::ST_M_W3;
            end
            bud_pkg::ST_M_W3:
            begin
                node_next = node_reg >> 1;
                if ((node_reg >> 1) == AW'(1))
                begin
                    status_next = bud_pkg::STAT_OK;
                    done_next   = 1'b1;
                    state_next  = bud_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bud_pkg::ST_M_RD;
                end
            end
            default:
            begin
                state_next = bud_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.rd_en = 1'b0;
        req.wr_en = 1'b0;
        req.addr  = node_reg;
        req.wdata = bud_pkg::NODE_UNUSED;
        unique case (state_reg)
            bud_pkg::ST_A_RD, bud_pkg::ST_F_RD:
            begin
                req.rd_en = 1'b1;
            end
            bud_pkg::ST_M_RD:
            begin
                req.rd_en = 1'b1;
                req.addr  = node_reg ^ AW'(1);
            end
            bud_pkg::ST_A_SPL:
            begin
                req.wr_en = 1'b1;
                req.wdata = bud_pkg::NODE_SPLIT;
            end
            bud_pkg::ST_A_SPR:
            begin
                req.wr_en = 1'b1;
                req.addr  = node_x2 | AW'(1);
                req.wdata = bud_pkg::NODE_FREE;
            end
            bud_pkg::ST_A_USE:
            begin
                req.wr_en = 1'b1;
                req.wdata = bud_pkg::NODE_USED;
            end
            bud_pkg::ST_F_WR:
            begin
                req.wr_en = 1'b1;
                req.wdata = bud_pkg::NODE_FREE;
            end
            bud_pkg::ST_M_W1:
            begin
                req.wr_en = 1'b1;
            end
            bud_pkg::ST_M_W2:
            begin
                req.wr_en = 1'b1;
                req.addr  = node_reg ^ AW'(1);
            end
            bud_pkg::ST_M_W3:
            begin
                req.wr_en = 1'b1;
                req.addr  = node_reg >> 1;
                req.wdata = bud_pkg::NODE_FREE;
            end
            default:
            begin
                req.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bud_pkg::ST_IDLE;
            done_reg   <= 1'b0;
            status_reg <= bud_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        dep_reg     <= dep_next;
        dmax_reg    <= dmax_next;
        off_reg     <= off_next;
        res_off_reg <= res_off_next;
        res_sz_reg  <= res_sz_next;
    end

    assign busy            = (state_reg != bud_pkg::ST_IDLE);
    assign done            = done_reg;
    assign block_offset    = (status_reg == bud_pkg::STAT_OK) ? res_off_reg : 6'd0;
    assign block_size_log2 = (status_reg == bud_pkg::STAT_OK) ? res_sz_reg : 3'd0;
    assign status          = status_reg;

endmodule

FILE: sv/buddy_block_allocator_core.sv
`timescale 1ns / 1ps
// Buddy allocator over a pool of up to 64 units, tree held in one node memory.
// Request: drive operation, request_size, free_offset with start high; the
// transfer happens at an edge where busy is low. busy stays high until the
// result is out. The result (block_offset, block_size_log2, status) shows for
// exactly one cycle with done high; the receiver cannot stall it.
// Steps share the single node memory port. Allocate walks the tree in address
// order, a read then an evaluate per node visited, then per split level marks
// the node split and its right child free, then marks the block used. Free
// walks down with a read and an evaluate per level, marks the block free, then
// per merge level reads and evaluates the buddy, marks both unused, parent free.
// Config: pool_size_log2_we writes pool_size_log2 (saturates at 6) and clears
// the tree to one free pool at once; write only while idle.
// Reset: pool_size_log2 is 6, the tree is one free pool, no result pending.
module buddy_block_allocator_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pool_size_log2_we,
    input  logic [2:0] pool_size_log2,
    input  logic       start,
    output logic       busy,
    input  logic       operation,
    input  logic [6:0] request_size,
    input  logic [5:0] free_offset,
    output logic       done,
    output logic [5:0] block_offset,
    output logic [2:0] block_size_log2,
    output logic [1:0] status
);

    logic [2:0]        cfg_reg;
    logic [2:0]        pool_log2;
    bud_pkg::mem_req_t req;
    bud_pkg::node_t    rd_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= 3'(bud_pkg::POOL_LOG2);
        end
        else if (pool_size_log2_we)
        begin
            cfg_reg <= pool_size_log2;
        end
    end

    assign pool_log2 = (cfg_reg > 3'(bud_pkg::POOL_LOG2)) ? 3'(bud_pkg::POOL_LOG2) : cfg_reg;

    bud_node_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (pool_size_log2_we),
        .req      (req),
        .rd_state (rd_state)
    );

    bud_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .pool_log2       (pool_log2),
        .start           (start),
        .operation       (operation),
        .request_size    (request_size),
        .free_offset     (free_offset),
        .rd_state        (rd_state),
        .req             (req),
        .busy            (busy),
        .done            (done),
        .block_offset    (block_offset),
        .block_size_log2 (block_size_log2),
        .status          (status)
    );

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted transfer did not start work");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != bud_pkg::STAT_OK |-> block_offset == 6'd0 && block_size_log2 == 3'd0)
        else $error("failed result carries payload");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status == bud_pkg::STAT_OK || status == bud_pkg::STAT_NO_FIT
                 || status == bud_pkg::STAT_BAD_OFF)
        else $error("bad status code");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.rd_en && req.wr_en))
        else $error("read and write in one cycle");

endmodule
